// ===== design/bdcl_pkg.sv =====
// Package: register map, reset values and result record for the button debouncer.
package bdcl_pkg;

	localparam int unsigned TS_W    = 32;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned LPC_W   = 16;
	localparam int unsigned CLK_W   = 8;
	localparam int unsigned PADDR_W = 4;

	localparam logic [CFG_W-1:0] DEF_SETTLE = 16'd10;
	localparam logic [CFG_W-1:0] DEF_LONG   = 16'd1000;
	localparam logic [CFG_W-1:0] DEF_CLICK  = 16'd200;
	localparam logic [CFG_W-1:0] DEF_REPEAT = 16'd100;

	localparam logic [CLK_W-1:0] CLICK_MAX  = '1;
	localparam logic [LPC_W-1:0] REPEAT_MAX = '1;

	typedef enum logic [1:0] {
		REG_SETTLE = 2'd0,
		REG_LONG   = 2'd1,
		REG_CLICK  = 2'd2,
		REG_REPEAT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic             level;
		logic             press_event;
		logic             release_event;
		logic             long_press_event;
		logic [LPC_W-1:0] long_press_count;
		logic             click_event;
		logic [CLK_W-1:0] click_count;
	} res_t;

	// Zero in the long, click or repeat register stands for its reset default
	function automatic logic [CFG_W-1:0] eff_val(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] dflt);
		return (v == '0) ? dflt : v;
	endfunction

endpackage

// ===== design/button_debounce_click_longpress_top.sv =====
// Top level: button debouncer with click series and long-press detection.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  in       | in_valid / in_ready  | pressed_raw, now
//  out      | out_valid/out_ready  | level, press/release/long_press/click events,
//           |                      | long_press_count, click_count
//  cfg      | APB psel/penable     | paddr[3:2] selects register, pwdata[15:0]
//
// One request per cycle sustained while out_ready keeps the output register free;
// an accepted request passes the _s1 input register, then the result register.
// The poll sits in the _s1 input register; one pass of subtract-and-compare logic
// against the state registers forms the result and the next state together.
// arst_n clears state, valid flags and loads the configuration defaults.
// A stalled output holds its result; the input register still drains into the
// output register in the same cycle the held result is taken.
module button_debounce_click_longpress_top
	import bdcl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// poll channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               pressed_raw,
	input  logic [TS_W-1:0]    now,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               level,
	output logic               press_event,
	output logic               release_event,
	output logic               long_press_event,
	output logic [LPC_W-1:0]   long_press_count,
	output logic               click_event,
	output logic [CLK_W-1:0]   click_count,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// ---------------- configuration registers ----------------
	logic [CFG_W-1:0] settle_q, long_q, click_q, repeat_q;
	logic             cfg_wr;
	cfg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = cfg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= DEF_SETTLE;
			long_q   <= DEF_LONG;
			click_q  <= DEF_CLICK;
			repeat_q <= DEF_REPEAT;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SETTLE: settle_q <= pwdata[CFG_W-1:0];
				REG_LONG:   long_q   <= pwdata[CFG_W-1:0];
				REG_CLICK:  click_q  <= pwdata[CFG_W-1:0];
				REG_REPEAT: repeat_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_SETTLE: prdata = {16'd0, settle_q};
			REG_LONG:   prdata = {16'd0, long_q};
			REG_CLICK:  prdata = {16'd0, click_q};
			REG_REPEAT: prdata = {16'd0, repeat_q};
			default:    prdata = '0;
		endcase
	end

	// Effective thresholds, widened to timestamp width for the compares
	logic [TS_W-1:0] settle_w, thr_w, civ_w, riv_w;
	assign settle_w = {16'd0, settle_q};
	assign thr_w    = {16'd0, eff_val(long_q, DEF_LONG)};
	assign civ_w    = {16'd0, eff_val(click_q, DEF_CLICK)};
	assign riv_w    = {16'd0, eff_val(repeat_q, DEF_REPEAT)};

	// ---------------- input register and flow control ----------------
	logic            valid_s1;
	logic            raw_s1;
	logic [TS_W-1:0] now_s1;
	logic            out_valid_q;
	logic            adv;

	// Advance the held poll whenever the output register is free or being emptied
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			raw_s1 <= pressed_raw;
			now_s1 <= now;
		end
	end

	// ---------------- debounce state ----------------
	logic             stable_q, pend_q, seen_q;
	logic [TS_W-1:0]  pend_start_q, press_time_q, release_time_q, rep_time_q;
	logic [LPC_W-1:0] rep_cnt_q;
	logic [CLK_W-1:0] clicks_q;

	logic             stable_n, pend_n, seen_n;
	logic [TS_W-1:0]  pend_start_n, press_time_n, release_time_n, rep_time_n;
	logic [LPC_W-1:0] rep_cnt_n;
	logic [CLK_W-1:0] clicks_n;
	logic [TS_W-1:0]  d_pend, d_press_old, d_hold, d_rep, d_rel;
	res_t             res;

	assign d_pend      = now_s1 - pend_start_q;
	assign d_press_old = now_s1 - press_time_q;
	assign d_rep       = now_s1 - rep_time_q;

	always_comb begin
		stable_n       = stable_q;
		pend_n         = pend_q;
		seen_n         = seen_q;
		pend_start_n   = pend_start_q;
		press_time_n   = press_time_q;
		release_time_n = release_time_q;
		rep_time_n     = rep_time_q;
		rep_cnt_n      = rep_cnt_q;
		clicks_n       = clicks_q;
		res            = '0;

		// Settle wait: confirm or drop a pending level change
		if (pend_q) begin
			if (d_pend >= settle_w) begin
				if (raw_s1 != stable_q) begin
					if (raw_s1) begin
						press_time_n      = now_s1;
						seen_n            = 1'b1;
						res.press_event   = 1'b1;
					end else begin
						release_time_n    = now_s1;
						res.release_event = 1'b1;
						rep_cnt_n         = '0;
						// short hold counts as a click, long one ends the series
						if (d_press_old < thr_w) begin
							if (clicks_q != CLICK_MAX) begin
								clicks_n = clicks_q + 1'b1;
							end
						end else begin
							clicks_n = '0;
						end
					end
				end
				stable_n = raw_s1;
				pend_n   = 1'b0;
			end
		end else if (raw_s1 != stable_q) begin
			pend_start_n = now_s1;
			pend_n       = 1'b1;
		end

		// A press confirmed in this poll leaves zero hold time; likewise a release
		d_hold = now_s1 - press_time_n;
		d_rel  = now_s1 - release_time_n;

		// Long press start and repeats while held
		if (stable_n) begin
			if (rep_cnt_n == '0) begin
				if (seen_n && (d_hold > thr_w)) begin
					rep_cnt_n            = 16'd1;
					rep_time_n           = now_s1;
					res.long_press_event = 1'b1;
					res.long_press_count = 16'd1;
				end
			end else if (d_rep > riv_w) begin
				rep_time_n = now_s1;
				if (rep_cnt_n != REPEAT_MAX) begin
					rep_cnt_n = rep_cnt_n + 1'b1;
				end
				res.long_press_event = 1'b1;
				res.long_press_count = rep_cnt_n;
			end
		end

		// Report the click series once released long enough
		if ((clicks_n != '0) && !stable_n && (d_rel > civ_w)) begin
			res.click_event = 1'b1;
			res.click_count = clicks_n;
			clicks_n        = '0;
		end

		res.level = stable_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q       <= 1'b0;
			pend_q         <= 1'b0;
			seen_q         <= 1'b0;
			pend_start_q   <= '0;
			press_time_q   <= '0;
			release_time_q <= '0;
			rep_time_q     <= '0;
			rep_cnt_q      <= '0;
			clicks_q       <= '0;
		end else if (adv) begin
			stable_q       <= stable_n;
			pend_q         <= pend_n;
			seen_q         <= seen_n;
			pend_start_q   <= pend_start_n;
			press_time_q   <= press_time_n;
			release_time_q <= release_time_n;
			rep_time_q     <= rep_time_n;
			rep_cnt_q      <= rep_cnt_n;
			clicks_q       <= clicks_n;
		end
	end

	// ---------------- result register ----------------
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign level            = res_q.level;
	assign press_event      = res_q.press_event;
	assign release_event    = res_q.release_event;
	assign long_press_event = res_q.long_press_event;
	assign long_press_count = res_q.long_press_count;
	assign click_event      = res_q.click_event;
	assign click_count      = res_q.click_count;

endmodule

// ===== design/bdcl_checker.sv =====
// Checker on the top-level ports of the button debouncer, bound to the top level.
module bdcl_checker
	import bdcl_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic             level,
	input logic             press_event,
	input logic             release_event,
	input logic             long_press_event,
	input logic [LPC_W-1:0] long_press_count,
	input logic             click_event,
	input logic [CLK_W-1:0] click_count
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level)
			&& $stable(long_press_count) && $stable(click_count))
		else $error("stalled result changed");

	a_press_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && press_event |-> level && !release_event)
		else $error("press event without pressed level");

	a_release_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && release_event |-> !level && !long_press_event)
		else $error("release event with pressed level or long press");

	a_long_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (long_press_event ? (long_press_count != '0) && level
			: (long_press_count == '0)))
		else $error("long press count inconsistent");

	a_click_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (click_event ? (click_count != '0) && !level
			: (click_count == '0)))
		else $error("click count inconsistent");

endmodule

bind button_debounce_click_longpress_top bdcl_checker u_bdcl_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.level            (level),
	.press_event      (press_event),
	.release_event    (release_event),
	.long_press_event (long_press_event),
	.long_press_count (long_press_count),
	.click_event      (click_event),
	.click_count      (click_count)
);
